// ===== hw/rtl/pfe_pkg.sv =====
// Shared types, character codes, error codes and the control store of the
// postfix evaluator. No dependencies; the top level, pfe_alu and the testbench use it.
package pfe_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_WIDTH      = 8;
  localparam int RESULT_WIDTH    = 32;
  localparam int ERR_WIDTH       = 3;
  localparam int UPC_WIDTH       = 4;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MUL   = 8'h2a;
  localparam logic [CHAR_WIDTH-1:0] CHAR_DIV   = 8'h2f;
  localparam logic [CHAR_WIDTH-1:0] CHAR_REM   = 8'h25;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_OK      = 3'd0,
    ERR_UNDER   = 3'd1,
    ERR_OVER    = 3'd2,
    ERR_DIVZERO = 3'd3,
    ERR_INVALID = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_REM = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    A_NOP      = 4'd0,
    A_DIGIT    = 4'd1,
    A_PUSH_NUM = 4'd2,
    A_READ_R   = 4'd3,
    A_READ_L   = 4'd4,
    A_START    = 4'd5,
    A_PUSH_RES = 4'd6,
    A_DROP     = 4'd7,
    A_READ_TOP = 4'd8,
    A_EMIT     = 4'd9
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_ACCEPT = 4'd2,
    C_DIGIT     = 4'd3,
    C_SPACE     = 4'd4,
    C_INVALID   = 4'd5,
    C_CNT_LT2   = 4'd6,
    C_ALU_BUSY  = 4'd7,
    C_NOT_LAST  = 4'd8,
    C_OUT_FULL  = 4'd9
  } cond_t;

  typedef struct packed {
    act_t                 act;
    cond_t                cond;
    logic [UPC_WIDTH-1:0] target;
  } ctrl_t;

  localparam logic [UPC_WIDTH-1:0] UPC_IDLE = 4'd0;
  localparam logic [UPC_WIDTH-1:0] UPC_WAIT = 4'd7;
  localparam logic [UPC_WIDTH-1:0] UPC_DROP = 4'd9;
  localparam logic [UPC_WIDTH-1:0] UPC_LAST = 4'd10;
  localparam logic [UPC_WIDTH-1:0] UPC_EMIT = 4'd13;

  // Control store: a step either jumps to its target when its condition holds
  // or moves on to the next step.
  function automatic ctrl_t ucode_rom(input logic [UPC_WIDTH-1:0] upc);
    ctrl_t c;
    case (upc)
      4'd0:    c = '{act: A_NOP,      cond: C_NO_ACCEPT, target: UPC_IDLE};
      4'd1:    c = '{act: A_DIGIT,    cond: C_DIGIT,     target: UPC_LAST};
      4'd2:    c = '{act: A_PUSH_NUM, cond: C_SPACE,     target: UPC_LAST};
      4'd3:    c = '{act: A_NOP,      cond: C_INVALID,   target: UPC_DROP};
      4'd4:    c = '{act: A_READ_R,   cond: C_CNT_LT2,   target: UPC_LAST};
      4'd5:    c = '{act: A_READ_L,   cond: C_NEVER,     target: UPC_IDLE};
      4'd6:    c = '{act: A_START,    cond: C_NEVER,     target: UPC_IDLE};
      4'd7:    c = '{act: A_NOP,      cond: C_ALU_BUSY,  target: UPC_WAIT};
      4'd8:    c = '{act: A_PUSH_RES, cond: C_ALWAYS,    target: UPC_LAST};
      4'd9:    c = '{act: A_DROP,     cond: C_NEVER,     target: UPC_IDLE};
      4'd10:   c = '{act: A_NOP,      cond: C_NOT_LAST,  target: UPC_IDLE};
      4'd11:   c = '{act: A_PUSH_NUM, cond: C_NEVER,     target: UPC_IDLE};
      4'd12:   c = '{act: A_READ_TOP, cond: C_NEVER,     target: UPC_IDLE};
      4'd13:   c = '{act: A_EMIT,     cond: C_OUT_FULL,  target: UPC_EMIT};
      default: c = '{act: A_NOP,      cond: C_ALWAYS,    target: UPC_IDLE};
    endcase
    return c;
  endfunction

  // The first error of an expression sticks.
  function automatic err_t flag_err(input err_t cur, input err_t code);
    return (cur == ERR_OK) ? code : cur;
  endfunction

endpackage

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// Top level of the postfix evaluator: control store sequencer, operand stack
// and datapath. Depends on pfe_pkg, pfe_ram and pfe_alu.
//
// The input channel takes one ASCII character per word, with end_of_expr set
// on the last character of an expression. Digits build a decimal number;
// a space or an operator ends it and pushes it. The output channel gives one
// word per expression: the value popped from the stack top and the first
// error seen (underflow, overflow, divide by zero, invalid symbol).
// A step counter walks a small program, one step per cycle, holding on a step
// while the multiply and divide unit is busy or the output register is full.
// A digit extends the number being built; any other character pushes it first,
// and an expression's last character also emits the stack top. An operator
// with two operands pushes their sum or difference or, for *, / or %, the result
// of the one-bit-per-cycle multiply and divide unit, zero on a divide by zero.
// in_stall is high while a character is being worked on. A result waits in the
// output register while out_stall is high; the next expression is taken
// meanwhile, and only its own last character holds the sequencer until the
// output register is free. Reset clears the stack count, the number being built,
// the sticky error and the output valid; stack entries are not cleared.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pfe_pkg::CHAR_WIDTH-1:0]    in_char_code,
  input  logic                              in_end_of_expr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pfe_pkg::RESULT_WIDTH-1:0]  out_result_value,
  output logic [pfe_pkg::ERR_WIDTH-1:0]     out_error_code
);
  import pfe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [UPC_WIDTH-1:0]    upc_r, upc_nxt;
  logic [CHAR_WIDTH-1:0]   char_r;
  logic                    last_r;
  logic [VALUE_WIDTH-1:0]  acc_r, acc_nxt;
  logic                    in_num_r, in_num_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  err_t                    err_r, err_nxt;
  logic [VALUE_WIDTH-1:0]  ra_r, ra_nxt;
  logic [VALUE_WIDTH-1:0]  la_r, la_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RESULT_WIDTH-1:0] out_value_r, out_value_nxt;
  err_t                    out_err_r, out_err_nxt;

  ctrl_t                   ctrl;
  logic                    in_accept;
  logic                    is_digit, is_space, is_op, is_invalid;
  logic                    out_full;
  logic                    cond_true;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0]  ram_wdata, ram_rdata;
  alu_req_t                alu_req;
  logic                    alu_busy;
  logic [VALUE_WIDTH-1:0]  alu_result;
  alu_op_t                 alu_op;

  assign ctrl       = ucode_rom(upc_r);
  assign in_stall   = (upc_r != UPC_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign is_digit   = char_r inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_space   = (char_r == CHAR_SPACE);
  assign is_op      = char_r inside {CHAR_PLUS, CHAR_MINUS, CHAR_MUL, CHAR_DIV, CHAR_REM};
  assign is_invalid = !is_digit && !is_space && !is_op;
  assign out_full   = out_valid_r && out_stall;

  always_comb begin
    case (char_r)
      CHAR_DIV: alu_op = ALU_DIV;
      CHAR_REM: alu_op = ALU_REM;
      default:  alu_op = ALU_MUL;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_ACCEPT: cond_true = !in_accept;
      C_DIGIT:     cond_true = is_digit;
      C_SPACE:     cond_true = is_space;
      C_INVALID:   cond_true = is_invalid;
      C_CNT_LT2:   cond_true = (cnt_r < CW'(2));
      C_ALU_BUSY:  cond_true = alu_busy;
      C_NOT_LAST:  cond_true = !last_r;
      C_OUT_FULL:  cond_true = out_full;
      default:     cond_true = 1'b0;
    endcase
    upc_nxt = cond_true ? ctrl.target : upc_r + UPC_WIDTH'(1);
  end

  always_comb begin
    logic                   push;
    logic [VALUE_WIDTH-1:0] push_val;
    logic                   div_zero;
    push          = 1'b0;
    push_val      = acc_r;
    div_zero      = (char_r == CHAR_DIV || char_r == CHAR_REM) && (ra_r == '0);
    acc_nxt       = acc_r;
    in_num_nxt    = in_num_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    ra_nxt        = ra_r;
    la_nxt        = la_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_raddr     = AW'(cnt_r - CW'(1));
    alu_req       = '{start: 1'b0, op: alu_op};

    case (ctrl.act)
      A_DIGIT: begin
        if (is_digit) begin
          acc_nxt    = (acc_r << 3) + (acc_r << 1) + VALUE_WIDTH'(char_r - CHAR_ZERO);
          in_num_nxt = 1'b1;
        end
      end
      A_PUSH_NUM: begin
        push       = in_num_r;
        acc_nxt    = '0;
        in_num_nxt = 1'b0;
      end
      A_READ_R: begin
        if (cnt_r < CW'(2)) begin
          err_nxt = flag_err(err_r, ERR_UNDER);
        end
      end
      A_READ_L: begin
        ra_nxt    = ram_rdata;
        ram_raddr = AW'(cnt_r - CW'(2));
      end
      A_START: begin
        la_nxt        = ram_rdata;
        cnt_nxt       = cnt_r - CW'(2);
        alu_req.start = (char_r == CHAR_MUL || char_r == CHAR_DIV || char_r == CHAR_REM)
                        && !div_zero;
      end
      A_PUSH_RES: begin
        push = 1'b1;
        if (char_r == CHAR_PLUS) begin
          push_val = la_r + ra_r;
        end else if (char_r == CHAR_MINUS) begin
          push_val = la_r - ra_r;
        end else if (div_zero) begin
          push_val = '0;
          err_nxt  = flag_err(err_r, ERR_DIVZERO);
        end else begin
          push_val = alu_result;
        end
      end
      A_DROP: begin
        err_nxt = flag_err(err_r, ERR_INVALID);
        cnt_nxt = (cnt_r >= CW'(2)) ? cnt_r - CW'(2) : '0;
      end
      A_READ_TOP: begin
        if (cnt_r == '0) begin
          err_nxt = flag_err(err_r, ERR_UNDER);
        end
      end
      A_EMIT: begin
        if (!out_full) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (cnt_r == '0) ? '0 : RESULT_WIDTH'(signed'(ram_rdata));
          out_err_nxt   = err_r;
          cnt_nxt       = '0;
          acc_nxt       = '0;
          in_num_nxt    = 1'b0;
          err_nxt       = ERR_OK;
        end
      end
      default: begin
      end
    endcase

    ram_we    = 1'b0;
    ram_waddr = AW'(cnt_r);
    ram_wdata = push_val;
    if (push) begin
      if (cnt_r >= CW'(STACK_DEPTH)) begin
        err_nxt = flag_err(err_nxt, ERR_OVER);
      end else begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_IDLE;
      acc_r       <= '0;
      in_num_r    <= 1'b0;
      cnt_r       <= '0;
      err_r       <= ERR_OK;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      acc_r       <= acc_nxt;
      in_num_r    <= in_num_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_accept) begin
      char_r <= in_char_code;
      last_r <= in_end_of_expr;
    end
    ra_r        <= ra_nxt;
    la_r        <= la_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  pfe_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfe_alu #(
    .W (VALUE_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (la_nxt),
    .rhs    (ra_r),
    .busy   (alu_busy),
    .result (alu_result)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_error_code   = out_err_r;

endmodule

// ===== hw/rtl/pfe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pfe_alu.sv =====
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// Depends on pfe_pkg for the request type.
module pfe_alu #(
  parameter int W = pfe_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfe_pkg::alu_req_t req,
  input  logic [W-1:0]      lhs,
  input  logic [W-1:0]      rhs,
  output logic              busy,
  output logic [W-1:0]      result
);
  import pfe_pkg::*;

  localparam int CTW = $clog2(W + 1);

  logic [CTW-1:0] cnt_r, cnt_nxt;
  alu_op_t        op_r, op_nxt;
  logic           neg_q_r, neg_q_nxt;
  logic           neg_m_r, neg_m_nxt;
  logic [W-1:0]   x_r, x_nxt;
  logic [W-1:0]   y_r, y_nxt;
  logic [W-1:0]   p_r, p_nxt;

  always_comb begin
    logic         lneg, rneg;
    logic [W-1:0] lmag, rmag;
    logic [W:0]   sh, diff;
    lneg      = lhs[W-1];
    rneg      = rhs[W-1];
    lmag      = lneg ? (~lhs + W'(1)) : lhs;
    rmag      = rneg ? (~rhs + W'(1)) : rhs;
    sh        = {p_r, y_r[W-1]};
    diff      = sh - {1'b0, x_r};
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    neg_q_nxt = neg_q_r;
    neg_m_nxt = neg_m_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    p_nxt     = p_r;
    if (req.start) begin
      cnt_nxt   = CTW'(W);
      op_nxt    = req.op;
      neg_q_nxt = lneg ^ rneg;
      neg_m_nxt = lneg;
      p_nxt     = '0;
      if (req.op == ALU_MUL) begin
        x_nxt = lhs;
        y_nxt = rhs;
      end else begin
        x_nxt = rmag;
        y_nxt = lmag;
      end
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CTW'(1);
      if (op_r == ALU_MUL) begin
        p_nxt = p_r + (y_r[0] ? x_r : '0);
        x_nxt = x_r << 1;
        y_nxt = y_r >> 1;
      end else if (!diff[W]) begin
        p_nxt = diff[W-1:0];
        y_nxt = {y_r[W-2:0], 1'b1};
      end else begin
        p_nxt = sh[W-1:0];
        y_nxt = {y_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    op_r    <= op_nxt;
    neg_q_r <= neg_q_nxt;
    neg_m_r <= neg_m_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    p_r     <= p_nxt;
  end

  assign busy = (cnt_r != '0);

  always_comb begin
    case (op_r)
      ALU_MUL: result = p_r;
      ALU_DIV: result = neg_q_r ? (~y_r + W'(1)) : y_r;
      ALU_REM: result = neg_m_r ? (~p_r + W'(1)) : p_r;
      default: result = p_r;
    endcase
  end

endmodule

// ===== hw/rtl/pfe_checker.sv =====
// Port-level checks for the postfix evaluator, bound to its top level.
// Depends only on the ports of postfix_expression_evaluator.
module pfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_value,
  input logic [2:0]  out_error_code
);

  // Reset leaves the block ready with no result pending.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Every accepted character keeps the sequencer busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a word was accepted");

  // A result is only produced while the sequencer is working on a last character.
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result appeared while the sequencer was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_error_code))
    else $error("stalled result word changed");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_error_code   (out_error_code)
);

// ===== bench/tb_postfix_expression_evaluator.sv =====
// Self-checking testbench for the postfix expression evaluator: it drives character words,
// predicts each expression result and compares it at the output channel.
// Depends on pfe_pkg and postfix_expression_evaluator.

typedef logic [pfe_pkg::VALUE_WIDTH_DEF-1:0] stack_val_t;

typedef struct packed {
  logic [pfe_pkg::RESULT_WIDTH-1:0] value;
  pfe_pkg::err_t                    code;
} expr_answer_t;

class expr_scoreboard;
  stack_val_t    entries [pfe_pkg::STACK_DEPTH_DEF];
  int            fill;
  stack_val_t    digits_acc;
  bit            building;
  pfe_pkg::err_t first_err;
  expr_answer_t  pending_answers [$];
  int            fails;

  function new();
    fill       = 0;
    digits_acc = '0;
    building   = 1'b0;
    first_err  = pfe_pkg::ERR_OK;
    fails      = 0;
  endfunction

  function void note_err(input pfe_pkg::err_t code);
    if (first_err == pfe_pkg::ERR_OK) begin
      first_err = code;
    end
  endfunction

  function void push_val(input stack_val_t v);
    if (fill >= pfe_pkg::STACK_DEPTH_DEF) begin
      note_err(pfe_pkg::ERR_OVER);
    end else begin
      entries[fill] = v;
      fill++;
    end
  endfunction

  function void close_number();
    if (building) begin
      push_val(digits_acc);
    end
    digits_acc = '0;
    building   = 1'b0;
  endfunction

  function void apply_op(input logic [pfe_pkg::CHAR_WIDTH-1:0] c);
    stack_val_t lhs, rhs, res, mag_l, mag_r, q;
    if (fill < 2) begin
      note_err(pfe_pkg::ERR_UNDER);
      return;
    end
    rhs  = entries[fill-1];
    lhs  = entries[fill-2];
    fill -= 2;
    case (c)
      pfe_pkg::CHAR_PLUS:  res = lhs + rhs;
      pfe_pkg::CHAR_MINUS: res = lhs - rhs;
      pfe_pkg::CHAR_MUL:   res = lhs * rhs;
      default: begin
        if (rhs == '0) begin
          note_err(pfe_pkg::ERR_DIVZERO);
          res = '0;
        end else begin
          mag_l = ($signed(lhs) < 0) ? -lhs : lhs;
          mag_r = ($signed(rhs) < 0) ? -rhs : rhs;
          if (c == pfe_pkg::CHAR_DIV) begin
            q   = mag_l / mag_r;
            res = (($signed(lhs) < 0) != ($signed(rhs) < 0)) ? -q : q;
          end else begin
            q   = mag_l % mag_r;
            res = ($signed(lhs) < 0) ? -q : q;
          end
        end
      end
    endcase
    push_val(res);
  endfunction

  function void take_char(input logic [pfe_pkg::CHAR_WIDTH-1:0] c, input logic last);
    expr_answer_t ans;
    if (c >= pfe_pkg::CHAR_ZERO && c <= pfe_pkg::CHAR_NINE) begin
      digits_acc = digits_acc * 10 + stack_val_t'(c - pfe_pkg::CHAR_ZERO);
      building   = 1'b1;
    end else begin
      close_number();
      case (c)
        pfe_pkg::CHAR_SPACE: ;
        pfe_pkg::CHAR_PLUS, pfe_pkg::CHAR_MINUS, pfe_pkg::CHAR_MUL,
        pfe_pkg::CHAR_DIV, pfe_pkg::CHAR_REM: apply_op(c);
        default: begin
          note_err(pfe_pkg::ERR_INVALID);
          if (fill > 0) fill--;
          if (fill > 0) fill--;
        end
      endcase
    end
    if (last) begin
      close_number();
      ans.value = '0;
      if (fill == 0) begin
        note_err(pfe_pkg::ERR_UNDER);
      end else begin
        ans.value = entries[fill-1];
        fill--;
      end
      ans.code = first_err;
      pending_answers.push_back(ans);
      fill       = 0;
      digits_acc = '0;
      building   = 1'b0;
      first_err  = pfe_pkg::ERR_OK;
    end
  endfunction

  function void check_result(input logic [pfe_pkg::RESULT_WIDTH-1:0] value,
                             input logic [pfe_pkg::ERR_WIDTH-1:0] code);
    expr_answer_t want;
    if (pending_answers.size() == 0) begin
      $display("%0t: unexpected result word, actual value %0d error %0d",
               $time, $signed(value), code);
      fails++;
      return;
    end
    want = pending_answers.pop_front();
    if (value !== want.value) begin
      $display("%0t: result_value expected %0d actual %0d",
               $time, $signed(want.value), $signed(value));
      fails++;
    end
    if (code !== want.code) begin
      $display("%0t: error_code expected %0d actual %0d", $time, want.code, code);
      fails++;
    end
  endfunction
endclass

module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [CHAR_WIDTH-1:0]   in_char_code   = '0;
  logic                    in_end_of_expr = 1'b0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic [RESULT_WIDTH-1:0] out_result_value;
  logic [ERR_WIDTH-1:0]    out_error_code;

  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    words_sent    = 0;
  logic [CHAR_WIDTH-1:0] expr_chars [$];
  logic [CHAR_WIDTH-1:0] op_chars [5] = '{CHAR_PLUS, CHAR_MINUS, CHAR_MUL, CHAR_DIV, CHAR_REM};
  expr_scoreboard        board;

  postfix_expression_evaluator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_expr   (in_end_of_expr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      board.check_result(out_result_value, out_error_code);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_word(input logic [CHAR_WIDTH-1:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_expr <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.take_char(c, last);
    words_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) begin
      send_word(expr_chars[i], i == expr_chars.size() - 1);
    end
    expr_chars.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_chars.push_back(s[i]);
    end
  endtask

  task automatic add_number(input longint unsigned v);
    logic [CHAR_WIDTH-1:0] digs [$];
    logic [CHAR_WIDTH-1:0] d;
    do begin
      d = CHAR_ZERO + CHAR_WIDTH'(v % 10);
      digs.push_front(d);
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) expr_chars.push_back(digs[i]);
  endtask

  function automatic longint unsigned pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 64'($urandom_range(0, 9));
    if (sel < 70) return 64'($urandom_range(0, 999));
    if (sel < 85) return 64'($urandom);
    if (sel < 95) begin
      case ($urandom_range(0, 3))
        0:       return 64'd0;
        1:       return 64'h8000_0000;
        2:       return 64'hFFFF_FFFF;
        default: return 64'h7FFF_FFFF;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  task automatic build_wellformed(input int operands);
    int fill, pushed;
    bit after_number;
    fill         = 0;
    pushed       = 0;
    after_number = 1'b0;
    while (pushed < operands || fill > 1) begin
      if (pushed < operands && (fill < 2 || $urandom_range(0, 1) == 1)) begin
        if (after_number || $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) expr_chars.push_back(CHAR_SPACE);
        end
        add_number(pick_value());
        fill++;
        pushed++;
        after_number = 1'b1;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 2)) expr_chars.push_back(CHAR_SPACE);
        end
        expr_chars.push_back(op_chars[$urandom_range(0, 4)]);
        fill--;
        after_number = 1'b0;
      end
    end
    if ($urandom_range(0, 3) == 0) expr_chars.push_back(CHAR_SPACE);
  endtask

  task automatic run_phase(input int quota);
    int goal, n, sel, pos;
    goal = words_sent + quota;
    n = $urandom_range(60, 68);
    repeat (n) begin
      add_number(64'($urandom_range(0, 9)));
      expr_chars.push_back(CHAR_SPACE);
    end
    repeat ($urandom_range(0, n - 1)) expr_chars.push_back(op_chars[$urandom_range(0, 4)]);
    send_expr();
    while (words_sent < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        build_wellformed($urandom_range(1, $urandom_range(2, 8)));
      end else if (sel < 77) begin
        build_wellformed($urandom_range(1, 6));
        pos = $urandom_range(0, expr_chars.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_chars[pos] = CHAR_WIDTH'($urandom_range(0, 255));
          1: expr_chars[pos] = op_chars[$urandom_range(0, 4)];
          default: if (expr_chars.size() > 1) void'(expr_chars.pop_back());
        endcase
      end else if (sel < 82) begin
        add_number(64'h8000_0000);
        expr_chars.push_back(CHAR_SPACE);
        add_number(64'hFFFF_FFFF);
        expr_chars.push_back($urandom_range(0, 1) ? CHAR_DIV : CHAR_REM);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0, 1: expr_chars.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
            2:    expr_chars.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
            default: begin
              if ($urandom_range(0, 5) == 0) expr_chars.push_back(CHAR_SPACE);
              else expr_chars.push_back(op_chars[$urandom_range(0, 4)]);
            end
          endcase
        end
      end
      send_expr();
    end
  endtask

  initial begin
    int waited;
    board = new();
    send_idle_pct = 32;
    recv_idle_pct = 52;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_text("5");
    send_expr();
    add_text(" ");
    send_expr();
    add_text("+");
    send_expr();
    add_text("9 4%3*2/1-5+");
    send_expr();
    add_text("1 0/");
    send_expr();
    add_text("3 4");
    expr_chars.push_back(8'hFF);
    send_expr();
    expr_chars.push_back(8'h00);
    send_expr();

    run_phase(583);
    send_idle_pct = 52;
    recv_idle_pct = 32;
    run_phase(583);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(584);
    in_valid <= 1'b0;

    waited = 0;
    while (board.pending_answers.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (board.pending_answers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               board.pending_answers.size());
      board.fails++;
    end
    if (board.fails == 0) begin
      $display("postfix_expression_evaluator verification clean");
    end else begin
      $display("postfix_expression_evaluator verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("postfix_expression_evaluator verification failed");
    $finish;
  end
endmodule
